FILE: rtl/ates_pkg.sv
// shared types, constants and codes for the ansi terminal screen engine
`default_nettype none
package ates_pkg;

  // default geometry
  localparam int SCREEN_ROWS_DEF = 25;
  localparam int SCREEN_COLS_DEF = 80;
  localparam int MAX_PARAMS_DEF  = 8;

  // largest parameter value
  localparam logic [15:0] PARAM_MAX = 16'hffff;

  // byte codes
  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_ESC   = 8'h1b;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_DEL   = 8'h7f;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_SEMI  = 8'h3b;
  localparam logic [7:0] CH_QUES  = 8'h3f;
  localparam logic [7:0] CH_LBR   = 8'h5b;
  localparam logic [7:0] CH_SEVEN = 8'h37;
  localparam logic [7:0] CH_EIGHT = 8'h38;
  localparam logic [7:0] CH_LOW_C = 8'h63;
  localparam logic [7:0] CH_UP_M  = 8'h4d;

  // csi finals
  localparam logic [7:0] FIN_CUP  = 8'h48;
  localparam logic [7:0] FIN_HVP  = 8'h66;
  localparam logic [7:0] FIN_ED   = 8'h4a;
  localparam logic [7:0] FIN_EL   = 8'h4b;
  localparam logic [7:0] FIN_CUU  = 8'h41;
  localparam logic [7:0] FIN_CUD  = 8'h42;
  localparam logic [7:0] FIN_CUF  = 8'h43;
  localparam logic [7:0] FIN_CUB  = 8'h44;
  localparam logic [7:0] FIN_SGR  = 8'h6d;
  localparam logic [7:0] FIN_SCP  = 8'h73;
  localparam logic [7:0] FIN_RCP  = 8'h75;

  // sgr codes
  localparam logic [15:0] SGR_RESET   = 16'd0;
  localparam logic [15:0] SGR_INVERSE = 16'd7;
  localparam logic [15:0] SGR_NORMAL  = 16'd27;

  // erase modes
  localparam logic [15:0] ERASE_TO_END   = 16'd0;
  localparam logic [15:0] ERASE_TO_START = 16'd1;
  localparam logic [15:0] ERASE_ALL      = 16'd2;

  // request kinds
  localparam logic REQ_FEED = 1'b0;
  localparam logic REQ_READ = 1'b1;

  typedef enum logic [1:0] {
    PS_NORMAL  = 2'd0,
    PS_ESC     = 2'd1,
    PS_BRACKET = 2'd2,
    PS_PARAMS  = 2'd3
  } parse_state_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_COPY,
    ST_BLANK,
    ST_WRITE,
    ST_DONE
  } seq_state_t;

  typedef struct packed {
    logic       req_type;
    logic [7:0] char_in;
    logic [4:0] read_row;
    logic [6:0] read_col;
  } req_t;

  typedef struct packed {
    logic [7:0] cell_char;
    logic       cell_inverse;
    logic [4:0] cursor_row_out;
    logic [6:0] cursor_col_out;
    logic       in_sequence;
  } res_t;

  // blank cell: inverse bit over character
  localparam logic [8:0] CELL_BLANK = {1'b0, CH_SPACE};

endpackage
`default_nettype wire

FILE: rtl/ates_ram.sv
// generic single write port ram with registered read
`default_nettype none
module ates_ram #(
  parameter int WIDTH = 9,
  parameter int DEPTH = 2000
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

FILE: rtl/ansi_terminal_screen_engine_unit.sv
// top level of the ansi terminal screen engine
`default_nettype none
// Text terminal engine: each request either feeds one byte (text, control
// codes, ESC and CSI sequences) or reads one screen cell. Every request gives
// exactly one result. The screen lives in one RAM of rows*cols cells and a
// single address counter walks it for scrolls and erases, one cell a cycle.
// After reset the screen is blanked by the same walk, during which no
// request is taken. One request is worked at a time; in_stall is high while
// a request is in work.
module ansi_terminal_screen_engine_unit #(
  parameter int SCREEN_ROWS = ates_pkg::SCREEN_ROWS_DEF,
  parameter int SCREEN_COLS = ates_pkg::SCREEN_COLS_DEF,
  parameter int MAX_PARAMS  = ates_pkg::MAX_PARAMS_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire ates_pkg::req_t in_data,
  input  wire logic         in_valid,
  output logic              in_stall,
  output ates_pkg::res_t    out_data,
  output logic              out_valid,
  input  wire logic         out_stall
);

  localparam int CELLS = SCREEN_ROWS * SCREEN_COLS;
  localparam int AW    = $clog2(CELLS + 1);
  localparam int RAW   = $clog2(CELLS);
  localparam int RW    = $clog2(SCREEN_ROWS);
  localparam int CW    = $clog2(SCREEN_COLS + 1);
  localparam int PIW   = $clog2(MAX_PARAMS + 1);
  localparam int XW    = 18;

  localparam logic [AW-1:0] CELLS_A   = AW'(CELLS);
  localparam logic [AW-1:0] COLS_A    = AW'(SCREEN_COLS);
  localparam logic [AW-1:0] COPY_END  = AW'((SCREEN_ROWS - 1) * SCREEN_COLS);
  localparam logic [RW-1:0] LAST_ROW  = RW'(SCREEN_ROWS - 1);
  localparam logic [CW-1:0] COLS_C    = CW'(SCREEN_COLS);
  localparam logic [CW-1:0] LAST_COL  = CW'(SCREEN_COLS - 1);
  localparam logic [PIW-1:0] LAST_IDX = PIW'(MAX_PARAMS - 1);

  // control and cursor registers
  ates_pkg::seq_state_t   state, state_next;
  ates_pkg::parse_state_t ps, ps_next;
  logic [AW-1:0]  cnt, cnt_next;
  logic [AW-1:0]  sweep_end, sweep_end_next;
  logic           pend_write, pend_write_next;
  logic [AW-1:0]  pend_addr, pend_addr_next;
  logic [8:0]     pend_data, pend_data_next;
  logic           silent, silent_next;
  logic           is_read, is_read_next;
  logic           read_ok, read_ok_next;
  logic [RW-1:0]  cur_row, cur_row_next;
  logic [CW-1:0]  cur_col, cur_col_next;
  logic [RW-1:0]  saved_row, saved_row_next;
  logic [CW-1:0]  saved_col, saved_col_next;
  logic           pen_inverse, pen_inverse_next;
  logic [PIW-1:0] param_index, param_index_next;
  logic [15:0]    acc, acc_next;
  logic [15:0]    p0, p0_next;
  logic [15:0]    p1, p1_next;
  logic           meff_set, meff_set_next;
  logic           meff_val, meff_val_next;
  logic           out_valid_next;
  ates_pkg::res_t out_data_next;

  // ram ports
  logic           ram_we;
  logic [RAW-1:0] ram_waddr;
  logic [8:0]     ram_wdata;
  logic [RAW-1:0] ram_raddr;
  logic [8:0]     ram_rdata;

  ates_ram #(
    .WIDTH(9),
    .DEPTH(CELLS)
  ) u_screen (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // state and control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ates_pkg::ST_BLANK;
      ps          <= ates_pkg::PS_NORMAL;
      cnt         <= '0;
      sweep_end   <= CELLS_A;
      pend_write  <= 1'b0;
      silent      <= 1'b1;
      cur_row     <= '0;
      cur_col     <= '0;
      saved_row   <= '0;
      saved_col   <= '0;
      pen_inverse <= 1'b0;
      param_index <= '0;
      acc         <= '0;
      p0          <= '0;
      p1          <= '0;
      meff_set    <= 1'b0;
      meff_val    <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      state       <= state_next;
      ps          <= ps_next;
      cnt         <= cnt_next;
      sweep_end   <= sweep_end_next;
      pend_write  <= pend_write_next;
      silent      <= silent_next;
      cur_row     <= cur_row_next;
      cur_col     <= cur_col_next;
      saved_row   <= saved_row_next;
      saved_col   <= saved_col_next;
      pen_inverse <= pen_inverse_next;
      param_index <= param_index_next;
      acc         <= acc_next;
      p0          <= p0_next;
      p1          <= p1_next;
      meff_set    <= meff_set_next;
      meff_val    <= meff_val_next;
      out_valid   <= out_valid_next;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    pend_addr <= pend_addr_next;
    pend_data <= pend_data_next;
    is_read   <= is_read_next;
    read_ok   <= read_ok_next;
    out_data  <= out_data_next;
  end

  // helper values for the accept cycle
  logic [7:0]    ch;
  logic          is_digit;
  logic [15:0]   digit;
  logic [19:0]   acc_x10;
  logic [15:0]   acc_add;
  logic [AW-1:0] row_base;
  logic [AW-1:0] cur_addr;
  logic [AW-1:0] read_addr;
  logic          accept;
  logic [15:0]   s0, s1, arg0, arg1, cur_slot;
  logic          m_set;
  logic          m_val;
  logic [XW-1:0] sum_row, sum_col, dif_row, dif_col, tab_col;

  assign ch        = in_data.char_in;
  assign is_digit  = (ch >= ates_pkg::CH_ZERO) && (ch <= ates_pkg::CH_NINE);
  assign digit     = 16'(ch - ates_pkg::CH_ZERO);
  assign acc_x10   = 20'(acc) * 20'd10 + 20'(digit);
  assign acc_add   = (acc_x10 > 20'(ates_pkg::PARAM_MAX)) ? ates_pkg::PARAM_MAX : acc_x10[15:0];
  assign row_base  = AW'(cur_row) * COLS_A;
  assign cur_addr  = row_base + AW'(cur_col);
  assign read_addr = AW'(in_data.read_row) * COLS_A + AW'(in_data.read_col);
  assign accept    = in_valid && !in_stall;
  assign in_stall  = (state != ates_pkg::ST_IDLE);

  // slot values as seen by a csi final
  assign cur_slot = acc;
  assign s0   = (param_index == '0) ? acc : p0;
  assign s1   = (param_index == PIW'(1)) ? acc : p1;
  assign arg0 = (s0 != '0) ? s0 : 16'd1;
  assign arg1 = ((param_index != '0) && (s1 != '0)) ? s1 : 16'd1;

  // sgr effect of the slot being closed, folded into earlier slots
  always_comb begin
    m_set = meff_set;
    m_val = meff_val;
    if ((cur_slot == ates_pkg::SGR_RESET) || (cur_slot == ates_pkg::SGR_NORMAL)) begin
      m_set = 1'b1;
      m_val = 1'b0;
    end else if (cur_slot == ates_pkg::SGR_INVERSE) begin
      m_set = 1'b1;
      m_val = 1'b1;
    end
  end

  assign sum_row = XW'(cur_row) + XW'(arg0);
  assign sum_col = XW'(cur_col) + XW'(arg0);
  assign dif_row = XW'(cur_row) - XW'(arg0);
  assign dif_col = XW'(cur_col) - XW'(arg0);
  assign tab_col = (XW'(cur_col) + XW'(4)) & ~XW'(3);

  // sequencer, parser and ram control
  always_comb begin
    state_next       = state;
    ps_next          = ps;
    cnt_next         = cnt;
    sweep_end_next   = sweep_end;
    pend_write_next  = pend_write;
    pend_addr_next   = pend_addr;
    pend_data_next   = pend_data;
    silent_next      = silent;
    is_read_next     = is_read;
    read_ok_next     = read_ok;
    cur_row_next     = cur_row;
    cur_col_next     = cur_col;
    saved_row_next   = saved_row;
    saved_col_next   = saved_col;
    pen_inverse_next = pen_inverse;
    param_index_next = param_index;
    acc_next         = acc;
    p0_next          = p0;
    p1_next          = p1;
    meff_set_next    = meff_set;
    meff_val_next    = meff_val;
    out_valid_next   = out_valid && out_stall;
    out_data_next    = out_data;
    ram_we           = 1'b0;
    ram_waddr        = RAW'(cnt);
    ram_wdata        = ates_pkg::CELL_BLANK;
    ram_raddr        = RAW'(read_addr);

    case (state)
      ates_pkg::ST_IDLE: begin
        if (accept) begin
          state_next      = ates_pkg::ST_DONE;
          silent_next     = 1'b0;
          pend_write_next = 1'b0;
          pend_addr_next  = read_addr;
          is_read_next    = (in_data.req_type == ates_pkg::REQ_READ);
          read_ok_next    = (32'(in_data.read_row) < SCREEN_ROWS) &&
                            (32'(in_data.read_col) < SCREEN_COLS);
          if (in_data.req_type == ates_pkg::REQ_FEED) begin
            case (ps)
              // plain text and control codes
              ates_pkg::PS_NORMAL: begin
                if (ch == ates_pkg::CH_ESC) begin
                  ps_next = ates_pkg::PS_ESC;
                end else if (ch == ates_pkg::CH_LF) begin
                  cur_col_next = '0;
                  if (cur_row == LAST_ROW) begin
                    cnt_next   = '0;
                    state_next = ates_pkg::ST_COPY;
                  end else begin
                    cur_row_next = cur_row + RW'(1);
                  end
                end else if (ch == ates_pkg::CH_CR) begin
                  cur_col_next = '0;
                end else if ((ch == ates_pkg::CH_BS) || (ch == ates_pkg::CH_DEL)) begin
                  if (cur_col != '0) begin
                    cur_col_next = cur_col - CW'(1);
                  end
                end else if (ch == ates_pkg::CH_TAB) begin
                  cur_col_next = (tab_col >= XW'(SCREEN_COLS)) ? LAST_COL : CW'(tab_col);
                end else if ((ch >= ates_pkg::CH_SPACE) && (ch < ates_pkg::CH_DEL)) begin
                  pend_data_next = {pen_inverse, ch};
                  if (cur_col >= COLS_C) begin
                    cur_col_next = CW'(1);
                    if (cur_row == LAST_ROW) begin
                      pend_addr_next  = COPY_END;
                      pend_write_next = 1'b1;
                      cnt_next        = '0;
                      state_next      = ates_pkg::ST_COPY;
                    end else begin
                      cur_row_next    = cur_row + RW'(1);
                      pend_addr_next  = row_base + COLS_A;
                      state_next      = ates_pkg::ST_WRITE;
                    end
                  end else begin
                    cur_col_next   = cur_col + CW'(1);
                    pend_addr_next = cur_addr;
                    state_next     = ates_pkg::ST_WRITE;
                  end
                end
              end
              // byte after escape
              ates_pkg::PS_ESC: begin
                if (ch == ates_pkg::CH_LBR) begin
                  ps_next          = ates_pkg::PS_BRACKET;
                  param_index_next = '0;
                  acc_next         = '0;
                  meff_set_next    = 1'b0;
                  meff_val_next    = 1'b0;
                end else begin
                  ps_next          = ates_pkg::PS_NORMAL;
                  param_index_next = '0;
                  if (ch == ates_pkg::CH_LOW_C) begin
                    cur_row_next   = '0;
                    cur_col_next   = '0;
                    cnt_next       = '0;
                    sweep_end_next = CELLS_A;
                    state_next     = ates_pkg::ST_BLANK;
                  end else if (ch == ates_pkg::CH_SEVEN) begin
                    saved_row_next = cur_row;
                    saved_col_next = cur_col;
                  end else if (ch == ates_pkg::CH_EIGHT) begin
                    cur_row_next = saved_row;
                    cur_col_next = saved_col;
                  end else if (ch == ates_pkg::CH_UP_M) begin
                    if (cur_row == '0) begin
                      cnt_next   = '0;
                      state_next = ates_pkg::ST_COPY;
                    end else begin
                      cur_row_next = cur_row - RW'(1);
                    end
                  end
                end
              end
              // parameter bytes and finals
              default: begin
                if (is_digit) begin
                  acc_next = (ps == ates_pkg::PS_BRACKET) ? digit : acc_add;
                  ps_next  = ates_pkg::PS_PARAMS;
                end else if ((ch == ates_pkg::CH_QUES) && (ps == ates_pkg::PS_BRACKET)) begin
                  if (param_index == '0) begin
                    acc_next = '0;
                  end else begin
                    p0_next = '0;
                  end
                  ps_next = ates_pkg::PS_PARAMS;
                end else if (ch == ates_pkg::CH_SEMI) begin
                  if (param_index == '0) begin
                    p0_next = acc;
                  end
                  if (param_index == PIW'(1)) begin
                    p1_next = acc;
                  end
                  meff_set_next = m_set;
                  meff_val_next = m_val;
                  if (param_index >= LAST_IDX) begin
                    ps_next          = ates_pkg::PS_NORMAL;
                    param_index_next = '0;
                  end else begin
                    param_index_next = param_index + PIW'(1);
                    acc_next         = '0;
                  end
                end else begin
                  ps_next          = ates_pkg::PS_NORMAL;
                  param_index_next = '0;
                  case (ch)
                    ates_pkg::FIN_CUP, ates_pkg::FIN_HVP: begin
                      cur_row_next = (32'(arg0) > SCREEN_ROWS) ? LAST_ROW : RW'(arg0 - 16'd1);
                      cur_col_next = (32'(arg1) > SCREEN_COLS) ? LAST_COL : CW'(arg1 - 16'd1);
                    end
                    ates_pkg::FIN_ED: begin
                      if (s0 == ates_pkg::ERASE_TO_END) begin
                        cnt_next       = cur_addr;
                        sweep_end_next = CELLS_A;
                        state_next     = ates_pkg::ST_BLANK;
                      end else if (s0 == ates_pkg::ERASE_TO_START) begin
                        cnt_next       = '0;
                        sweep_end_next = cur_addr;
                        state_next     = ates_pkg::ST_BLANK;
                      end else if (s0 == ates_pkg::ERASE_ALL) begin
                        cnt_next       = '0;
                        sweep_end_next = CELLS_A;
                        state_next     = ates_pkg::ST_BLANK;
                      end
                    end
                    ates_pkg::FIN_EL: begin
                      if (s0 == ates_pkg::ERASE_TO_END) begin
                        cnt_next       = cur_addr;
                        sweep_end_next = row_base + COLS_A;
                        state_next     = ates_pkg::ST_BLANK;
                      end else if (s0 == ates_pkg::ERASE_TO_START) begin
                        cnt_next       = row_base;
                        sweep_end_next = cur_addr;
                        state_next     = ates_pkg::ST_BLANK;
                      end else if (s0 == ates_pkg::ERASE_ALL) begin
                        cnt_next       = row_base;
                        sweep_end_next = row_base + COLS_A;
                        state_next     = ates_pkg::ST_BLANK;
                      end
                    end
                    ates_pkg::FIN_CUU: begin
                      cur_row_next = (XW'(arg0) > XW'(cur_row)) ? '0 : RW'(dif_row);
                    end
                    ates_pkg::FIN_CUD: begin
                      cur_row_next = (sum_row >= XW'(SCREEN_ROWS)) ? LAST_ROW : RW'(sum_row);
                    end
                    ates_pkg::FIN_CUF: begin
                      cur_col_next = (sum_col >= XW'(SCREEN_COLS)) ? LAST_COL : CW'(sum_col);
                    end
                    ates_pkg::FIN_CUB: begin
                      cur_col_next = (XW'(arg0) > XW'(cur_col)) ? '0 : CW'(dif_col);
                    end
                    ates_pkg::FIN_SGR: begin
                      if (m_set) begin
                        pen_inverse_next = m_val;
                      end
                    end
                    ates_pkg::FIN_SCP: begin
                      saved_row_next = cur_row;
                      saved_col_next = cur_col;
                    end
                    ates_pkg::FIN_RCP: begin
                      cur_row_next = saved_row;
                      cur_col_next = saved_col;
                    end
                    default: begin
                    end
                  endcase
                end
              end
            endcase
          end
        end
      end
      // move rows up by one: read one row ahead, write it in the following cycle
      ates_pkg::ST_COPY: begin
        ram_raddr = RAW'(cnt + COLS_A);
        ram_waddr = RAW'(cnt - AW'(1));
        ram_wdata = ram_rdata;
        ram_we    = (cnt != '0);
        if (cnt == COPY_END) begin
          sweep_end_next = CELLS_A;
          state_next     = ates_pkg::ST_BLANK;
        end else begin
          cnt_next = cnt + AW'(1);
        end
      end
      // blank a linear range of cells
      ates_pkg::ST_BLANK: begin
        if (cnt < sweep_end) begin
          ram_we   = 1'b1;
          cnt_next = cnt + AW'(1);
        end else if (pend_write) begin
          state_next = ates_pkg::ST_WRITE;
        end else if (silent) begin
          state_next = ates_pkg::ST_IDLE;
        end else begin
          state_next = ates_pkg::ST_DONE;
        end
      end
      // single cell write for a printable byte
      ates_pkg::ST_WRITE: begin
        ram_we          = 1'b1;
        ram_waddr       = RAW'(pend_addr);
        ram_wdata       = pend_data;
        pend_write_next = 1'b0;
        state_next      = ates_pkg::ST_DONE;
      end
      // hand the result over once the output register is free
      ates_pkg::ST_DONE: begin
        // keep the read address of the request so the cell holds while waiting
        ram_raddr = RAW'(pend_addr);
        if (!out_valid || !out_stall) begin
          out_valid_next               = 1'b1;
          out_data_next.cell_char      = (is_read && read_ok) ? ram_rdata[7:0] : 8'd0;
          out_data_next.cell_inverse   = is_read && read_ok && ram_rdata[8];
          out_data_next.cursor_row_out = 5'(cur_row);
          out_data_next.cursor_col_out = 7'(cur_col);
          out_data_next.in_sequence    = (ps != ates_pkg::PS_NORMAL);
          state_next                   = ates_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = ates_pkg::ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire
